[rtl/bct_pkg.sv]
// Shared types, widths and weight functions for the cubic Bezier flattener.
// No dependencies; every other file of the block imports this package.
package bct_pkg;

    // Number of line segments emitted for each curve
    localparam int SEGMENTS  = 10;
    localparam int DENOM_INT = SEGMENTS * SEGMENTS * SEGMENTS;

    localparam int IDX_W  = $clog2(SEGMENTS + 1);
    localparam int WGT_W  = $clog2(DENOM_INT + 1);
    // power-basis coefficients of 16-bit points stay within +/-12*2^15
    localparam int COEF_W = 20;
    localparam int PROD_W = COEF_W + WGT_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ACC_W  = PROD_W + 3;
    // biased numerator lies in [0, 2^16 * 2 * S^3)
    localparam int DIV_W  = WGT_W + 18;
    localparam int QUO_W  = 16;

    localparam logic [WGT_W-1:0] DENOM = WGT_W'(DENOM_INT);
    // rounding term S^3 plus a bias of 2^15 * 2 * S^3, so the quotient is unsigned
    localparam logic [ACC_W-1:0] NUM_OFFSET = (ACC_W'(DENOM) << 16) + ACC_W'(DENOM);

    // exact floor division by 2*S^3 as a multiply by a rounded-up reciprocal
    localparam int DIVISOR_INT = 2 * DENOM_INT;
    localparam int RECIP_SHIFT = DIV_W + $clog2(DIVISOR_INT);
    localparam int RECIP_W     = DIV_W + 1;
    localparam int MULQ_W      = DIV_W + RECIP_W;
    localparam longint unsigned RECIP_INT =
        ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR_INT) - 64'd1) / 64'(DIVISOR_INT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);

    typedef struct packed {
        logic signed [15:0] p0_x_coord;
        logic signed [15:0] p0_y_coord;
        logic signed [15:0] p1_x_coord;
        logic signed [15:0] p1_y_coord;
        logic signed [15:0] p2_x_coord;
        logic signed [15:0] p2_y_coord;
        logic signed [15:0] p3_x_coord;
        logic signed [15:0] p3_y_coord;
    } in_t;

    typedef struct packed {
        logic signed [15:0] seg_start_x;
        logic signed [15:0] seg_start_y;
        logic signed [15:0] seg_end_x;
        logic signed [15:0] seg_end_y;
        logic               last_segment;
    } out_t;

    // Power-basis coefficients of one axis
    typedef struct packed {
        logic signed [15:0]       c0;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c3;
    } coef_t;

    // One segment issued into the evaluation pipeline
    typedef struct packed {
        coef_t            cx;
        coef_t            cy;
        logic [WGT_W-1:0] w1;
        logic [WGT_W-1:0] w2;
        logic [WGT_W-1:0] w3;
        logic             first;
        logic             last;
    } seg_t;

    // Sideband that rides along with each segment
    typedef struct packed {
        logic               first;
        logic               last;
        logic signed [15:0] p0_x;
        logic signed [15:0] p0_y;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [DIV_W-1:0] num_x;
        logic [DIV_W-1:0] num_y;
    } num_t;

    // i * S^2
    function automatic logic [WGT_W-1:0] weight_lin(input logic [IDX_W-1:0] i);
        logic [WGT_W-1:0] iw;
        iw = WGT_W'(i);
        return iw * WGT_W'(SEGMENTS * SEGMENTS);
    endfunction

    // i^2 * S
    function automatic logic [WGT_W-1:0] weight_sq(input logic [IDX_W-1:0] i);
        logic [WGT_W-1:0] iw;
        iw = WGT_W'(i);
        return iw * iw * WGT_W'(SEGMENTS);
    endfunction

    // i^3
    function automatic logic [WGT_W-1:0] weight_cu(input logic [IDX_W-1:0] i);
        logic [WGT_W-1:0] iw;
        iw = WGT_W'(i);
        return iw * iw * iw;
    endfunction

    // signed coefficient times unsigned weight
    function automatic logic signed [PROD_W-1:0] coef_mul(input logic signed [COEF_W-1:0] c,
                                                         input logic [WGT_W-1:0] w);
        return c * $signed({1'b0, w});
    endfunction

endpackage

[rtl/bct_seq.sv]
// Curve sequencer: captures one curve, derives its coefficients and issues
// one segment per cycle while a_ready allows, with its weights. Depends on bct_pkg.
module bct_seq import bct_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic a_valid,
    input  logic a_ready,
    output seg_t a_data
);

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    coef_t            cx_reg;
    coef_t            cy_reg;
    logic             a_valid_reg;
    seg_t             a_reg;
    coef_t            cx_next;
    coef_t            cy_next;
    logic             a_load;
    logic             issue;
    logic             issue_last;
    logic             s_accept;

    function automatic coef_t make_coef(input logic signed [15:0] p0,
                                        input logic signed [15:0] p1,
                                        input logic signed [15:0] p2,
                                        input logic signed [15:0] p3);
        coef_t                    c;
        logic signed [COEF_W-1:0] e0, e1, e2, e3, d1, t2, u3;
        e0   = COEF_W'(p0);
        e1   = COEF_W'(p1);
        e2   = COEF_W'(p2);
        e3   = COEF_W'(p3);
        d1   = e1 - e0;
        t2   = e0 - (e1 <<< 1) + e2;
        u3   = e1 - e2;
        c.c0 = p0;
        c.c1 = (d1 <<< 1) + d1;
        c.c2 = (t2 <<< 1) + t2;
        c.c3 = e3 - e0 + (u3 <<< 1) + u3;
        return c;
    endfunction

    // handshake: a new curve is taken while idle or while the last segment of the old one issues
    assign a_load     = !a_valid_reg || a_ready;
    assign issue      = busy_reg && a_load;
    assign issue_last = issue && (idx_reg == IDX_W'(SEGMENTS));
    assign s_ready    = !busy_reg || issue_last;
    assign s_accept   = s_valid && s_ready;

    assign cx_next = make_coef(s_data.p0_x_coord, s_data.p1_x_coord,
                               s_data.p2_x_coord, s_data.p3_x_coord);
    assign cy_next = make_coef(s_data.p0_y_coord, s_data.p1_y_coord,
                               s_data.p2_y_coord, s_data.p3_y_coord);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= IDX_W'(1);
            a_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                busy_reg <= 1'b1;
                idx_reg  <= IDX_W'(1);
            end else if (issue_last) begin
                busy_reg <= 1'b0;
            end else if (issue) begin
                idx_reg  <= idx_reg + IDX_W'(1);
            end
            if (a_load) begin
                a_valid_reg <= busy_reg;
            end
        end
    end

    // curve and issue registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
        if (issue) begin
            a_reg.cx    <= cx_reg;
            a_reg.cy    <= cy_reg;
            a_reg.w1    <= weight_lin(idx_reg);
            a_reg.w2    <= weight_sq(idx_reg);
            a_reg.w3    <= weight_cu(idx_reg);
            a_reg.first <= (idx_reg == IDX_W'(1));
            a_reg.last  <= (idx_reg == IDX_W'(SEGMENTS));
        end
    end

    assign a_valid = a_valid_reg;
    assign a_data  = a_reg;

    // a freshly taken curve starts at segment one
    ap_accept_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && idx_reg == IDX_W'(1)))
        else $error("curve accepted but sequencer did not restart at segment one");

    // segments of one curve issue without gaps
    ap_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && a_ready && !a_reg.last) |=> a_valid_reg)
        else $error("gap inside a curve's segment stream");

    ap_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg != IDX_W'(0) && idx_reg <= IDX_W'(SEGMENTS)))
        else $error("segment index out of range");

endmodule

[rtl/bct_eval.sv]
// Polynomial evaluation pipeline: products, partial sums and the biased
// numerator for both axes, three register stages. Depends on bct_pkg.
module bct_eval import bct_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic a_valid,
    output logic a_ready,
    input  seg_t a_data,
    output logic n_valid,
    input  logic n_ready,
    output num_t n_data
);

    typedef struct packed {
        tag_t                     tag;
        logic signed [PROD_W-1:0] tx0, tx1, tx2, tx3;
        logic signed [PROD_W-1:0] ty0, ty1, ty2, ty3;
    } prod_t;

    typedef struct packed {
        tag_t                    tag;
        logic signed [SUM_W-1:0] sx01, sx23;
        logic signed [SUM_W-1:0] sy01, sy23;
    } psum_t;

    prod_t b_reg;
    psum_t c_reg;
    num_t  d_reg;
    logic  b_valid_reg, c_valid_reg, d_valid_reg;
    logic  b_load, c_load, d_load;

    function automatic logic [DIV_W-1:0] biased_num(input logic signed [SUM_W-1:0] s01,
                                                    input logic signed [SUM_W-1:0] s23);
        logic [ACC_W-1:0] acc;
        acc = ((ACC_W'(s01) + ACC_W'(s23)) << 1) + NUM_OFFSET;
        return acc[DIV_W-1:0];
    endfunction

    // stall chain, bubbles are squeezed out
    assign d_load  = !d_valid_reg || n_ready;
    assign c_load  = !c_valid_reg || d_load;
    assign b_load  = !b_valid_reg || c_load;
    assign a_ready = b_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (b_load) b_valid_reg <= a_valid;
            if (c_load) c_valid_reg <= b_valid_reg;
            if (d_load) d_valid_reg <= c_valid_reg;
        end
    end

    // products of coefficients and weights
    always_ff @(posedge aclk) begin
        if (b_load && a_valid) begin
            b_reg.tag.first <= a_data.first;
            b_reg.tag.last  <= a_data.last;
            b_reg.tag.p0_x  <= a_data.cx.c0;
            b_reg.tag.p0_y  <= a_data.cy.c0;
            b_reg.tx0 <= coef_mul(COEF_W'(a_data.cx.c0), DENOM);
            b_reg.tx1 <= coef_mul(a_data.cx.c1, a_data.w1);
            b_reg.tx2 <= coef_mul(a_data.cx.c2, a_data.w2);
            b_reg.tx3 <= coef_mul(a_data.cx.c3, a_data.w3);
            b_reg.ty0 <= coef_mul(COEF_W'(a_data.cy.c0), DENOM);
            b_reg.ty1 <= coef_mul(a_data.cy.c1, a_data.w1);
            b_reg.ty2 <= coef_mul(a_data.cy.c2, a_data.w2);
            b_reg.ty3 <= coef_mul(a_data.cy.c3, a_data.w3);
        end
    end

    // pairwise sums
    always_ff @(posedge aclk) begin
        if (c_load && b_valid_reg) begin
            c_reg.tag  <= b_reg.tag;
            c_reg.sx01 <= SUM_W'(b_reg.tx0) + SUM_W'(b_reg.tx1);
            c_reg.sx23 <= SUM_W'(b_reg.tx2) + SUM_W'(b_reg.tx3);
            c_reg.sy01 <= SUM_W'(b_reg.ty0) + SUM_W'(b_reg.ty1);
            c_reg.sy23 <= SUM_W'(b_reg.ty2) + SUM_W'(b_reg.ty3);
        end
    end

    // 2N + S^3 plus bias
    always_ff @(posedge aclk) begin
        if (d_load && c_valid_reg) begin
            d_reg.tag   <= c_reg.tag;
            d_reg.num_x <= biased_num(c_reg.sx01, c_reg.sx23);
            d_reg.num_y <= biased_num(c_reg.sy01, c_reg.sy23);
        end
    end

    assign n_valid = d_valid_reg;
    assign n_data  = d_reg;

endmodule

[rtl/bct_div.sv]
// Constant divider by 2*S^3 as a reciprocal multiply for both axes, followed
// by the result register that chains segment starts. Depends on bct_pkg.
module bct_div import bct_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic n_valid,
    output logic n_ready,
    input  num_t n_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic               q_valid_reg;
    tag_t               q_tag_reg;
    logic [QUO_W-1:0]   q_x_reg;
    logic [QUO_W-1:0]   q_y_reg;
    logic               m_valid_reg;
    out_t               out_reg;
    logic signed [15:0] prev_x_reg;
    logic signed [15:0] prev_y_reg;
    logic               q_load;
    logic               m_load;
    logic [MULQ_W-1:0]  prod_x;
    logic [MULQ_W-1:0]  prod_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;

    // stall chain
    assign m_load  = !m_valid_reg || m_ready;
    assign q_load  = !q_valid_reg || m_load;
    assign n_ready = q_load;

    // floor(num / 2S^3) is the top of num * RECIP for every DIV_W-bit numerator
    assign prod_x = MULQ_W'(n_data.num_x) * MULQ_W'(RECIP);
    assign prod_y = MULQ_W'(n_data.num_y) * MULQ_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_load) q_valid_reg <= n_valid;
            if (m_load) m_valid_reg <= q_valid_reg;
        end
    end

    // quotient register
    always_ff @(posedge aclk) begin
        if (q_load && n_valid) begin
            q_tag_reg <= n_data.tag;
            q_x_reg   <= prod_x[RECIP_SHIFT +: QUO_W];
            q_y_reg   <= prod_y[RECIP_SHIFT +: QUO_W];
        end
    end

    // remove the bias: quotient minus 2^15 flips the top bit
    assign end_x = {~q_x_reg[QUO_W-1], q_x_reg[QUO_W-2:0]};
    assign end_y = {~q_y_reg[QUO_W-1], q_y_reg[QUO_W-2:0]};

    // result register, start point is p0 or the previous end
    always_ff @(posedge aclk) begin
        if (m_load && q_valid_reg) begin
            out_reg.seg_start_x  <= q_tag_reg.first ? q_tag_reg.p0_x : prev_x_reg;
            out_reg.seg_start_y  <= q_tag_reg.first ? q_tag_reg.p0_y : prev_y_reg;
            out_reg.seg_end_x    <= end_x;
            out_reg.seg_end_y    <= end_y;
            out_reg.last_segment <= q_tag_reg.last;
            prev_x_reg           <= end_x;
            prev_y_reg           <= end_y;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

[rtl/bezier_curve_tessellator_core.sv]
// Cubic Bezier flattener: one curve in, SEGMENTS line segments out.
// After the curve is accepted, each segment passes through 1 issue stage, 3 evaluation
// stages, 1 reciprocal multiply stage and 1 result register.
// Throughput: one segment per cycle while m_ready stays high, set by the sequencer, which
// takes a new curve as the last segment of the previous one issues into the shared pipeline.
// Reset (aresetn low, synchronous) clears all valid bits and the sequencer.
module bezier_curve_tessellator_core import bct_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic a_valid, a_ready;
    seg_t a_data;
    logic n_valid, n_ready;
    num_t n_data;

    // curve capture and segment issue
    bct_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .a_data  (a_data)
    );

    // polynomial evaluation
    bct_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .a_data  (a_data),
        .n_valid (n_valid),
        .n_ready (n_ready),
        .n_data  (n_data)
    );

    // constant division and result assembly
    bct_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .n_valid (n_valid),
        .n_ready (n_ready),
        .n_data  (n_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[verif/bct_checker.sv]
// Scoreboard for the cubic Bezier flattener: predicts the segments of each accepted curve
// and compares every accepted segment with the oldest prediction.
// Depends on bct_pkg for the item types and SEGMENTS.
module bct_checker import bct_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   pending_count,
    output int   checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    out_t expected_segs[$];
    int   errors  = 0;
    int   checked = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    // One coordinate of the curve point at t = i/SEGMENTS, rounded half up
    function automatic logic signed [15:0] curve_point(input longint a0, input longint a1,
                                                       input longint a2, input longint a3,
                                                       input longint i);
        longint s, d, c1, c2, c3, n, num, den, q;
        s   = SEGMENTS;
        d   = s * s * s;
        c1  = 3 * (a1 - a0);
        c2  = 3 * a0 - 6 * a1 + 3 * a2;
        c3  = -a0 + 3 * a1 - 3 * a2 + a3;
        n   = a0 * d + c1 * i * s * s + c2 * i * i * s + c3 * i * i * i;
        num = 2 * n + d;
        den = 2 * d;
        q   = num / den;
        // division truncates towards zero; step down to the floor
        if (num % den < 0) begin
            q = q - 1;
        end
        return q[15:0];
    endfunction

    // Queue the full chain of segments for one curve
    task automatic flatten_curve(input in_t c);
        out_t seg;
        logic signed [15:0] px, py;
        px = c.p0_x_coord;
        py = c.p0_y_coord;
        for (int k = 1; k <= SEGMENTS; k++) begin
            seg.seg_start_x  = px;
            seg.seg_start_y  = py;
            seg.seg_end_x    = curve_point(c.p0_x_coord, c.p1_x_coord, c.p2_x_coord,
                                           c.p3_x_coord, k);
            seg.seg_end_y    = curve_point(c.p0_y_coord, c.p1_y_coord, c.p2_y_coord,
                                           c.p3_y_coord, k);
            seg.last_segment = (k == SEGMENTS);
            expected_segs.push_back(seg);
            px = seg.seg_end_x;
            py = seg.seg_end_y;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                flatten_curve(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_segs.size() == 0) begin
                    $display("%0t: segment with no curve pending: start (%0d,%0d) end (%0d,%0d)",
                             $time, m_data.seg_start_x, m_data.seg_start_y,
                             m_data.seg_end_x, m_data.seg_end_y);
                    errors++;
                end else begin
                    want = expected_segs.pop_front();
                    check_field("seg_start_x", want.seg_start_x, m_data.seg_start_x);
                    check_field("seg_start_y", want.seg_start_y, m_data.seg_start_y);
                    check_field("seg_end_x", want.seg_end_x, m_data.seg_end_x);
                    check_field("seg_end_y", want.seg_end_y, m_data.seg_end_y);
                    check_field("last_segment", longint'(want.last_segment),
                                longint'(m_data.last_segment));
                    checked++;
                end
            end
        end
        fail_count    <= errors;
        pending_count <= expected_segs.size();
        checked_count <= checked;
    end

endmodule

[verif/tb_bezier_curve_tessellator_core.sv]
// Testbench top for bezier_curve_tessellator_core: clock, reset, curve stimulus,
// random back-pressure, watchdog and verdict. Depends on bct_pkg and bct_checker.
module tb_bezier_curve_tessellator_core;
    import bct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CURVES = 280;
    localparam int QUIET_TAIL    = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 30;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   curves_sent = 0;
    int   idle_cycles = 0;
    logic idle_on = 1'b1;

    always #5 aclk = ~aclk;

    bezier_curve_tessellator_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bct_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // Watchdog: too long without any item moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: bursts of stall between stretches of ready, always ready while idling is off
    initial begin
        int run;
        m_ready = 1'b0;
        forever begin
            if (!idle_on) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                run = $urandom_range(1, 11);
                repeat (run) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                run = $urandom_range(1, 20);
                repeat (run) begin
                    @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    function automatic in_t make_curve(input int x0, input int y0, input int x1, input int y1,
                                       input int x2, input int y2, input int x3, input int y3);
        in_t c;
        c.p0_x_coord = x0[15:0];
        c.p0_y_coord = y0[15:0];
        c.p1_x_coord = x1[15:0];
        c.p1_y_coord = y1[15:0];
        c.p2_x_coord = x2[15:0];
        c.p2_y_coord = y2[15:0];
        c.p3_x_coord = x3[15:0];
        c.p3_y_coord = y3[15:0];
        return c;
    endfunction

    // Full range, small values that often land on rounding ties, or near the extremes
    function automatic logic [15:0] rand_coord(input int mode);
        logic [15:0] v;
        case (mode)
            0: v = 16'($urandom_range(0, 32)) - 16'd16;
            1: v = ($urandom_range(0, 1) == 1) ? 16'h7FFF - 16'($urandom_range(0, 7))
                                                : 16'h8000 + 16'($urandom_range(0, 7));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Offer one curve, optionally after a gap, and hold it until accepted
    task automatic send_curve(input in_t c);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        curves_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    initial begin
        in_t c;
        int  mode;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, zig-zag hulls, rounding ties, degenerate curves
        send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0));
        send_curve(make_curve(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_curve(make_curve(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_curve(make_curve(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768));
        send_curve(make_curve(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767));
        // halfway cases: positive rounds up, negative rounds towards zero
        send_curve(make_curve(0, 0, 0, 0, 0, 0, 4, -4));
        send_curve(make_curve(0, 0, 0, 0, 0, 0, 12, -12));
        send_curve(make_curve(0, 0, 1, -1, -1, 1, 0, 0));
        // straight line and a closed loop
        send_curve(make_curve(-48, -48, -16, -16, 16, 16, 48, 48));
        send_curve(make_curve(100, -200, 32767, 32767, -32768, 32767, 100, -200));
        // one field at its maximum, the rest at the minimum
        for (int k = 0; k < 8; k++) begin
            c = {8{16'h8000}};
            c[127 - 16 * k -: 16] = 16'h7FFF;
            send_curve(c);
        end

        // Pause until every queued segment has come out
        wait_drained();

        // Random curves, idling switched off for a middle stretch and the tail
        for (int n = 0; n < RANDOM_CURVES; n++) begin
            idle_on = !((n >= 80 && n < 140) || n >= RANDOM_CURVES - QUIET_TAIL);
            mode = $urandom_range(0, 5);
            for (int k = 0; k < 8; k++) begin
                c[127 - 16 * k -: 16] = rand_coord(mode < 3 ? mode : $urandom_range(0, 2));
            end
            send_curve(c);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d curves: directed extremes, rounding ties and degenerate shapes,",
                 curves_sent);
        $display("then random coordinates with and without stalls; %0d segments checked.",
                 checked_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[bezier_curve_tessellator_core.f]
rtl/bct_pkg.sv
rtl/bct_seq.sv
rtl/bct_eval.sv
rtl/bct_div.sv
rtl/bezier_curve_tessellator_core.sv
verif/bct_checker.sv
verif/tb_bezier_curve_tessellator_core.sv
